// File: rtl/core/srg_pkg.sv
// Shared constants, types and arithmetic helpers for the subtractive random generator.
package srg_pkg;

    localparam int unsigned ValueW = 30;
    localparam int unsigned SeedW  = 28;
    localparam int unsigned IdxW   = 6;

    localparam logic [ValueW-1:0] Modulus    = 30'd1000000000;
    localparam logic [ValueW-1:0] SeedConst  = 30'd161803398;
    localparam logic [IdxW-1:0]   TableLen   = 6'd55;
    localparam logic [IdxW-1:0]   Stride     = 6'd21;
    localparam logic [IdxW-1:0]   MixOffset  = 6'd30;
    localparam logic [IdxW-1:0]   SecondInit = 6'd31;
    localparam logic [IdxW-1:0]   WrapIdx    = 6'd56;
    localparam logic [1:0]        LastPass   = 2'd3;
    localparam logic [SeedW-1:0]  SeedReset  = 28'd1;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_FILL   = 6'b000010,
        S_MIX_RD = 6'b000100,
        S_MIX_WR = 6'b001000,
        S_GEN_RD = 6'b010000,
        S_GEN_WR = 6'b100000
    } t_state;

    typedef struct packed {
        logic              we;
        logic [IdxW-1:0]   waddr;
        logic [ValueW-1:0] wdata;
        logic [IdxW-1:0]   raddr_a;
        logic [IdxW-1:0]   raddr_b;
    } t_mem_req;

    // a - b modulo 10^9, both operands below 10^9
    function automatic logic [ValueW-1:0] sub_mod(input logic [ValueW-1:0] a,
                                                  input logic [ValueW-1:0] b);
        logic [ValueW-1:0] d;
        d = a - b;
        if (a >= b) begin
            return d;
        end else begin
            return d + Modulus;
        end
    endfunction

    // step a lag pointer, wrapping past the last entry back to the first
    function automatic logic [IdxW-1:0] advance(input logic [IdxW-1:0] idx);
        logic [IdxW-1:0] n;
        n = idx + 6'd1;
        if (n >= WrapIdx || n == 6'd0) begin
            return 6'd1;
        end else begin
            return n;
        end
    endfunction

endpackage

// File: rtl/core/srg_mem.sv
// Lag table storage: one write port, two registered read ports.
module srg_mem (
    input  logic                          i_clk,
    input  srg_pkg::t_mem_req             i_req,
    output logic [srg_pkg::ValueW-1:0]    o_rd_a,
    output logic [srg_pkg::ValueW-1:0]    o_rd_b
);
    import srg_pkg::*;

    logic [ValueW-1:0] mem [1:55];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
        o_rd_a <= mem[i_req.raddr_a];
        o_rd_b <= mem[i_req.raddr_b];
    end

endmodule

// File: rtl/core/srg_ctrl.sv
// Sequencer for table rebuild, mixing passes and number generation.
module srg_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [srg_pkg::SeedW-1:0]     i_cfg_seed,
    input  logic                          i_in_valid,
    input  logic                          i_in_reseed,
    input  logic                          i_out_free,
    output logic                          o_in_ready,
    output logic                          o_res_valid,
    output logic [srg_pkg::ValueW-1:0]    o_res_value,
    output srg_pkg::t_mem_req             o_mem_req,
    input  logic [srg_pkg::ValueW-1:0]    i_rd_a,
    input  logic [srg_pkg::ValueW-1:0]    i_rd_b
);
    import srg_pkg::*;

    t_state            r_state, n_state;
    logic              r_seeded, n_seeded;
    logic [SeedW-1:0]  r_seed;
    logic [IdxW-1:0]   r_fi, n_fi, r_si, n_si;
    logic [IdxW-1:0]   r_cnt, n_cnt, r_slot, n_slot;
    logic [1:0]        r_pass, n_pass;
    logic [ValueW-1:0] r_prev, n_prev, r_next, n_next;

    logic [IdxW-1:0]   fi_adv, si_adv, mix_slot;
    logic [IdxW:0]     slot_sum, mix_sum;
    logic [ValueW-1:0] seed_ext, start, diff;
    logic              accept;

    assign fi_adv   = advance(r_fi);
    assign si_adv   = advance(r_si);
    // partner entry for mixing: 1 + (i + 30) mod 55, kept one bit wider
    assign mix_sum  = {1'b0, r_cnt} + {1'b0, MixOffset};
    assign mix_slot = (mix_sum < {1'b0, TableLen}) ? IdxW'(mix_sum + 7'd1)
                                                   : IdxW'(mix_sum - {1'b0, TableLen} + 7'd1);
    assign slot_sum = {1'b0, r_slot} + {1'b0, Stride};
    assign seed_ext = {{(ValueW-SeedW){1'b0}}, r_seed};
    // seed is below 2^28, so the distance stays below the modulus
    assign start    = (seed_ext <= SeedConst) ? (SeedConst - seed_ext) : (seed_ext - SeedConst);
    assign diff     = sub_mod(i_rd_a, i_rd_b);

    assign o_in_ready = (r_state == S_IDLE) && i_out_free;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state  = r_state;
        n_seeded = r_seeded;
        n_fi     = r_fi;
        n_si     = r_si;
        n_cnt    = r_cnt;
        n_slot   = r_slot;
        n_pass   = r_pass;
        n_prev   = r_prev;
        n_next   = r_next;
        o_res_valid       = 1'b0;
        o_res_value       = diff;
        o_mem_req.we      = 1'b0;
        o_mem_req.waddr   = r_fi;
        o_mem_req.wdata   = diff;
        o_mem_req.raddr_a = fi_adv;
        o_mem_req.raddr_b = si_adv;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_in_reseed || !r_seeded) begin
                        n_state = S_FILL;
                        n_cnt   = '0;
                    end else begin
                        n_fi    = fi_adv;
                        n_si    = si_adv;
                        n_state = S_GEN_WR;
                    end
                end
            end
            S_FILL: begin
                o_mem_req.we = 1'b1;
                if (r_cnt == '0) begin
                    o_mem_req.waddr = TableLen;
                    o_mem_req.wdata = start;
                    n_prev = start;
                    n_next = {{(ValueW-1){1'b0}}, 1'b1};
                    n_slot = Stride;
                end else begin
                    o_mem_req.waddr = r_slot;
                    o_mem_req.wdata = r_next;
                    n_next = sub_mod(r_prev, r_next);
                    n_prev = r_next;
                    n_slot = (slot_sum >= {1'b0, TableLen}) ? IdxW'(slot_sum - {1'b0, TableLen})
                                                            : slot_sum[IdxW-1:0];
                end
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == TableLen - 6'd1) begin
                    n_state = S_MIX_RD;
                    n_cnt   = 6'd1;
                    n_pass  = '0;
                end
            end
            S_MIX_RD: begin
                o_mem_req.raddr_a = r_cnt;
                o_mem_req.raddr_b = mix_slot;
                n_state = S_MIX_WR;
            end
            S_MIX_WR: begin
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = r_cnt;
                n_state = S_MIX_RD;
                n_cnt   = r_cnt + 6'd1;
                if (r_cnt == TableLen) begin
                    n_cnt  = 6'd1;
                    n_pass = r_pass + 2'd1;
                    if (r_pass == LastPass) begin
                        n_state  = S_GEN_RD;
                        n_fi     = '0;
                        n_si     = SecondInit;
                        n_seeded = 1'b1;
                    end
                end
            end
            S_GEN_RD: begin
                n_fi    = fi_adv;
                n_si    = si_adv;
                n_state = S_GEN_WR;
            end
            S_GEN_WR: begin
                o_mem_req.we = 1'b1;
                o_res_valid  = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_seeded <= 1'b0;
            r_seed   <= SeedReset;
            r_fi     <= '0;
            r_si     <= SecondInit;
            r_cnt    <= '0;
            r_pass   <= '0;
        end else begin
            r_state  <= n_state;
            r_seeded <= n_seeded;
            r_fi     <= n_fi;
            r_si     <= n_si;
            r_cnt    <= n_cnt;
            r_pass   <= n_pass;
            if (i_cfg_we) begin
                r_seed <= i_cfg_seed;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
        r_prev <= n_prev;
        r_next <= n_next;
    end

endmodule

// File: rtl/core/subtractive_random_generator_top.sv
// Top level of the subtractive lagged random number generator.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid/s_axis_tready    tdata[0] reseed, [7:1] zero
//  m_axis    out  m_axis_tvalid/m_axis_tready    tdata[29:0] value, [31:30] zero
//  cfg       in   i_cfg_we                       i_cfg_wdata seed_magnitude
//
// A request on a built table reads the lag table at the accept edge, then
// subtracts, writes back and loads the output register.
// The next beat is accepted only once that result is loaded and the output
// register is free, so a new request waits for the table read/write round trip.
// A rebuild (first request after reset, or reseed set) adds a fill of all 55
// entries, 4 mixing passes (55 entries x read + write) and a lag-pair read.
// Reset is synchronous, active low; it clears control state and the seed to 1.
// A stalled result holds in the output register and blocks new input beats.
module subtractive_random_generator_top (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [srg_pkg::SeedW-1:0] i_cfg_wdata,   // seed_magnitude
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [7:0]                s_axis_tdata,  // [0] reseed, [7:1] zero
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [31:0]               m_axis_tdata   // [29:0] value, [31:30] zero
);
    import srg_pkg::*;

    t_mem_req          mem_req;
    logic [ValueW-1:0] rd_a, rd_b;
    logic              res_valid;
    logic [ValueW-1:0] res_value;
    logic              out_free;
    logic              r_out_valid;
    logic [ValueW-1:0] r_out_value;

    // output register is free when empty or draining this cycle
    assign out_free = !r_out_valid || m_axis_tready;

    srg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_seed  (i_cfg_wdata),
        .i_in_valid  (s_axis_tvalid),
        .i_in_reseed (s_axis_tdata[0]),
        .i_out_free  (out_free),
        .o_in_ready  (s_axis_tready),
        .o_res_valid (res_valid),
        .o_res_value (res_value),
        .o_mem_req   (mem_req),
        .i_rd_a      (rd_a),
        .i_rd_b      (rd_b)
    );

    srg_mem u_mem (
        .i_clk  (i_clk),
        .i_req  (mem_req),
        .o_rd_a (rd_a),
        .o_rd_b (rd_b)
    );

    // hold the result until the consumer takes the beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out_value <= res_value;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_value};

endmodule

// File: rtl/core/srg_checker.sv
// Port-level assertions for the subtractive random generator, bound to the top level.
module srg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    // results always lie below the modulus, padding bits zero
    a_value_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[29:0] < 30'd1000000000 && m_axis_tdata[31:30] == 2'b00))
        else $error("result out of range");

    // a stalled result blocks new input beats
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted while result stalled");

    // an accepted beat is still being worked in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted back to back");

    // stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind subtractive_random_generator_top srg_checker u_srg_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
